/* hw/rtl/framed_packet_parser_macros.svh */
// ----------------------------------------------------------------------------
// framed_packet_parser assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_PARSER_MACROS_SVH
`define FRAMED_PACKET_PARSER_MACROS_SVH

// same-cycle implication
`define FPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fpp_pkg.sv */
// ----------------------------------------------------------------------------
// fpp_pkg
// constants and controller/datapath interface types for the frame parser
// ----------------------------------------------------------------------------
package fpp_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

  localparam int BYTE_W = 8;
  localparam int TIME_W = 32;
  localparam int IN_W   = BYTE_W + TIME_W;
  localparam int OUT_FIELDS_W = BYTE_W + 5 + 6;
  localparam int OUT_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [BYTE_W-1:0] HDR_FIRST     = 8'hAA;
  localparam logic [BYTE_W-1:0] HDR_SECOND    = 8'h55;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // input request taken this cycle
    logic load_len;    // latch length, restart count and sum
    logic store_byte;  // write payload byte, advance count and sum
    logic emit_load;   // move next result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic timed_out;
    logic is_hdr1;
    logic is_hdr2;
    logic len_ok;
    logic len_zero;
    logic fill_done;
    logic sum_match;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/framed_packet_parser.sv */
// the check byte of a good frame moves the controller to ST_EMIT, which loads
// the first result into the output register once that register is free
// throughput: one byte per cycle while parsing; a good frame then streams one
// result per cycle from the payload memory while the output is not stalled
// (n results, one for an empty frame); no input until the last result is loaded
// reset: synchronous; parse restarts hunting, timeout returns to 1000 ms
// ----------------------------------------------------------------------------
// framed_packet_parser
// byte-serial header/length/checksum frame parser with inter-byte timeout
// ----------------------------------------------------------------------------
module framed_packet_parser
  import fpp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TIME_W-1:0] cfg_data,   // timeout_ms
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,    // rx_byte[7:0], time_ms[39:8]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,    // payload_byte[7:0], byte_position[12:8],
                                        // frame_length[18:13], zero fill[23:19]
  output logic              m_tlast,    // last_of_frame
  output logic              m_tuser     // empty_frame
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  fpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

/* hw/rtl/fpp_dp.sv */
// ----------------------------------------------------------------------------
// fpp_dp
// frame parser datapath: timeout check, length/count/sum, payload memory,
// output register
// ----------------------------------------------------------------------------
module fpp_dp
  import fpp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [TIME_W-1:0] cfg_data,
  input  logic [IN_W-1:0]   s_tdata,
  input  logic              m_tready,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              m_tvalid,
  output logic [OUT_W-1:0]  m_tdata,
  output logic              m_tlast,
  output logic              m_tuser
);

  logic [BYTE_W-1:0] rx_byte;
  logic [TIME_W-1:0] time_ms;
  logic [TIME_W-1:0] timeout_ms;
  logic [TIME_W-1:0] prev_arrival;
  logic [TIME_W-1:0] gap;
  logic [LEN_W-1:0]  exp_len;
  logic [LEN_W-1:0]  fill_count;
  logic [LEN_W-1:0]  fill_inc;
  logic [LEN_W-1:0]  rd_inc;
  logic [BYTE_W-1:0] run_sum;
  logic [IDX_W-1:0]  rd_idx;
  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rd_data;
  logic [IDX_W-1:0]  out_pos;
  logic [LEN_W-1:0]  out_len;
  logic              out_last;
  logic              out_empty;
  logic              emit_last;

  assign rx_byte = s_tdata[BYTE_W-1:0];
  assign time_ms = s_tdata[IN_W-1:BYTE_W];
  assign gap     = time_ms - prev_arrival;

  assign fill_inc  = fill_count + LEN_W'(1);
  assign rd_inc    = LEN_W'(rd_idx) + LEN_W'(1);
  assign emit_last = (exp_len == '0) || (rd_inc == exp_len);

  always_comb begin
    sts.timed_out = gap > timeout_ms;
    sts.is_hdr1   = rx_byte == HDR_FIRST;
    sts.is_hdr2   = rx_byte == HDR_SECOND;
    sts.len_ok    = rx_byte <= BYTE_W'(MAX_PAYLOAD);
    sts.len_zero  = rx_byte == '0;
    sts.fill_done = fill_inc >= exp_len;
    sts.sum_match = run_sum == rx_byte;
    sts.emit_last = emit_last;
    sts.out_free  = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms   <= TIMEOUT_RESET;
      prev_arrival <= '0;
    end else begin
      if (cfg_valid) begin
        timeout_ms <= cfg_data;
      end
      if (cmd.accept) begin
        prev_arrival <= time_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_len) begin
      exp_len    <= rx_byte[LEN_W-1:0];
      fill_count <= '0;
      run_sum    <= rx_byte;
      rd_idx     <= '0;
    end else begin
      if (cmd.store_byte) begin
        fill_count <= fill_inc;
        run_sum    <= run_sum + rx_byte;
      end
      if (cmd.emit_load) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
    end
  end

  // payload memory, registered read feeds the output register
  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      mem[fill_count[IDX_W-1:0]] <= rx_byte;
    end
    if (cmd.emit_load) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_pos   <= rd_idx;
      out_len   <= exp_len;
      out_last  <= emit_last;
      out_empty <= exp_len == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {(OUT_W - OUT_FIELDS_W)'(0), out_len, out_pos,
                    out_empty ? BYTE_W'(0) : rd_data};
  assign m_tlast = out_last;
  assign m_tuser = out_empty;

endmodule

/* hw/rtl/fpp_ctrl.sv */
// ----------------------------------------------------------------------------
// fpp_ctrl
// frame parser controller: header/length/payload/check phases and result
// readout sequencing
// ----------------------------------------------------------------------------
module fpp_ctrl
  import fpp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_HUNT  = 3'd0;
  localparam logic [2:0] ST_HDR2  = 3'd1;
  localparam logic [2:0] ST_LEN   = 3'd2;
  localparam logic [2:0] ST_DATA  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] parse_state;
  logic       accept;

  assign s_tready = state != ST_EMIT;
  assign accept   = s_tvalid && s_tready;

  // a gap over the timeout restarts the parse before the byte is looked at
  assign parse_state = sts.timed_out ? ST_HUNT : state;

  always_comb begin
    state_next     = state;
    cmd.accept     = accept;
    cmd.load_len   = 1'b0;
    cmd.store_byte = 1'b0;
    cmd.emit_load  = 1'b0;
    if (state == ST_EMIT) begin
      if (sts.out_free) begin
        cmd.emit_load = 1'b1;
        if (sts.emit_last) begin
          state_next = ST_HUNT;
        end
      end
    end else if (accept) begin
      unique case (parse_state)
        ST_HDR2: begin
          state_next = sts.is_hdr2 ? ST_LEN : ST_HUNT;
        end
        ST_LEN: begin
          if (sts.len_ok) begin
            cmd.load_len = 1'b1;
            state_next   = sts.len_zero ? ST_CHECK : ST_DATA;
          end else begin
            state_next = ST_HUNT;
          end
        end
        ST_DATA: begin
          cmd.store_byte = 1'b1;
          state_next     = sts.fill_done ? ST_CHECK : ST_DATA;
        end
        ST_CHECK: begin
          state_next = sts.sum_match ? ST_EMIT : ST_HUNT;
        end
        default: begin
          state_next = sts.is_hdr1 ? ST_HDR2 : ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/fpp_checker.sv */
// ----------------------------------------------------------------------------
// fpp_checker
// port-level checks on the frame parser result stream
// ----------------------------------------------------------------------------
`include "framed_packet_parser_macros.svh"

module fpp_checker
  import fpp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_W-1:0]  m_tdata,
  input logic              m_tlast,
  input logic              m_tuser
);

  `FPP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata), "result request dropped or changed while stalled")
  `FPP_ASSERT_NOW(a_empty_shape, m_tvalid && m_tuser,
    m_tlast && (m_tdata[18:0] == 19'd0), "empty frame marker with nonzero fields or no last")
  `FPP_ASSERT_NOW(a_pos_in_frame, m_tvalid && !m_tuser,
    6'(m_tdata[12:8]) < m_tdata[18:13], "byte position outside frame length")
  `FPP_ASSERT_NOW(a_last_pos, m_tvalid && !m_tuser,
    m_tlast == ((6'(m_tdata[12:8]) + 6'd1) == m_tdata[18:13]),
    "last marker not on final payload byte")

endmodule

bind framed_packet_parser fpp_checker u_fpp_checker (.*);
